### sv/hlvs_pkg.sv
// ----------------------------------------------------------------------------
// hlvs_pkg
// Shared types, constants and elaboration-time helpers for the Hough line
// vote / suppress / mark block.
// ----------------------------------------------------------------------------
package hlvs_pkg;

  localparam int DEF_THETA_BINS = 180;
  localparam int DEF_RHO_BINS   = 512;
  localparam int DEF_COUNT_BITS = 17;

  localparam int MAX_SIDE     = 256;
  localparam int ITEM_Q_DEPTH = 2;
  localparam int RES_Q_DEPTH  = 2;

  // Fixed-point constants of the angle table and of the rho range.
  localparam logic [63:0] PI_Q30      = 64'd3373259426;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;
  localparam int          SIN_QUARTER_Q14 = 11585;

  // Register reset values.
  localparam logic [16:0] RST_THRESHOLD = 17'd100;
  localparam logic [8:0]  RST_WIDTH     = 9'd256;
  localparam logic [8:0]  RST_HEIGHT    = 9'd256;
  localparam logic [12:0] RST_RHO_RECIP = 13'd4096;

  // Width of the truncated rho magnitude: 25-bit magnitude times 13-bit
  // reciprocal, shifted down by 26.
  localparam int QW = 12;

  typedef enum logic [1:0] {
    MODE_VOTE     = 2'd0,
    MODE_SUPPRESS = 2'd1,
    MODE_QUERY    = 2'd2,
    MODE_CLEAR    = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_WIDTH     = 2'd1,
    CFG_HEIGHT    = 2'd2,
    CFG_RHO_RECIP = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_WALK,
    ST_SUPPRESS,
    ST_CLEAR,
    ST_RESULT
  } back_state_t;

  typedef enum logic [2:0] {
    SS_CENTER,
    SS_LEFT,
    SS_RIGHT,
    SS_UP,
    SS_DOWN,
    SS_DECIDE
  } sup_step_t;

  // One classified item as it travels from the front to the back.
  typedef struct packed {
    mode_t      mode;
    logic [7:0] row;
    logic [7:0] col;
    logic       active;
  } item_t;

  typedef struct packed {
    logic [16:0] threshold;
    logic [12:0] rho_recip;
  } back_cfg_t;

  function automatic logic [8:0] side_clip(input logic [8:0] v);
    return (32'(v) > MAX_SIDE) ? 9'(MAX_SIDE) : v;
  endfunction

  function automatic logic [15:0] q30_to_q14(input logic signed [63:0] v);
    logic signed [63:0] c;
    logic [63:0]        u;
    c = v;
    if (c < 0) c = 0;
    if (c > $signed(ONE_Q30)) c = $signed(ONE_Q30);
    u = c;
    return 16'((u + 64'd32768) >> 16);
  endfunction

endpackage

### sv/hlvs_ram.sv
// ----------------------------------------------------------------------------
// hlvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module hlvs_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem_r [DEPTH];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### sv/hlvs_fifo.sv
// ----------------------------------------------------------------------------
// hlvs_fifo
// Small register queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
module hlvs_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic          do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) begin
        wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (do_pop) begin
        rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= din;
    end
  end

endmodule

### sv/hlvs_front.sv
// ----------------------------------------------------------------------------
// hlvs_front
// Accepts input transactions, classifies each pixel against the image size
// and queues it for the back end.
// ----------------------------------------------------------------------------
module hlvs_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [1:0]           mode,
  input  logic [7:0]           pix_row,
  input  logic [7:0]           pix_col,
  input  logic [7:0]           pix_value,
  input  logic [8:0]           image_width,
  input  logic [8:0]           image_height,
  input  logic                 hold,
  output logic                 item_valid,
  output hlvs_pkg::item_t      item,
  input  logic                 item_pop
);

  import hlvs_pkg::*;

  item_t item_in;
  logic  q_full, q_empty;
  logic  in_image;
  logic [$bits(item_t)-1:0] q_dout;

  // A pixel takes part only when it is nonzero and inside the active image.
  assign in_image = (9'(pix_row) < side_clip(image_height)) &&
                    (9'(pix_col) < side_clip(image_width));

  always_comb begin
    item_in.mode   = mode_t'(mode);
    item_in.row    = pix_row;
    item_in.col    = pix_col;
    item_in.active = (pix_value != 8'd0) && in_image;
  end

  assign full = q_full || hold;

  hlvs_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (ITEM_Q_DEPTH)
  ) u_item_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push && !hold),
    .din   (item_in),
    .full  (q_full),
    .pop   (item_pop),
    .dout  (q_dout),
    .empty (q_empty)
  );

  assign item_valid = !q_empty;
  assign item       = item_t'(q_dout);

endmodule

### sv/hlvs_back.sv
// ----------------------------------------------------------------------------
// hlvs_back
// Executes queued items on the accumulator store: angle walk for votes and
// queries, in-place suppression sweep, and clearing sweep.
// ----------------------------------------------------------------------------
module hlvs_back #(
  parameter int THETA_BINS = hlvs_pkg::DEF_THETA_BINS,
  parameter int RHO_BINS   = hlvs_pkg::DEF_RHO_BINS,
  parameter int COUNT_BITS = hlvs_pkg::DEF_COUNT_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            item_valid,
  input  hlvs_pkg::item_t                 item,
  output logic                            item_pop,
  input  hlvs_pkg::back_cfg_t             cfg,
  input  logic [$clog2(RHO_BINS+1)-1:0]   rho_bins_used,
  output logic                            init_busy,
  output logic                            res_valid,
  output logic                            res_on_line,
  input  logic                            res_full
);

  import hlvs_pkg::*;

  localparam int ROWS   = THETA_BINS + 2;
  localparam int DEPTH  = 2 * ROWS * RHO_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(RHO_BINS);
  localparam int T_W    = $clog2(THETA_BINS);
  localparam int TC_W   = $clog2(THETA_BINS + 1);
  localparam int RBU_W  = $clog2(RHO_BINS + 1);
  localparam int SW     = (QW > RBU_W) ? QW : RBU_W;
  localparam int CMP_W  = (COUNT_BITS > 17) ? COUNT_BITS : 17;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // Sine and cosine of angle k*PI/THETA_BINS in Q1.14, from a Taylor
  // series in Q2.30 evaluated at elaboration.
  function automatic logic [31:0] rom_entry(input int unsigned k);
    logic [63:0]        a, x, x2, ts, tc;
    logic signed [63:0] ss, sc;
    logic               back_h;
    logic [15:0]        s14, c14, cv;
    a      = (PI_Q30 * 64'(k)) / 64'(THETA_BINS);
    back_h = a > HALF_PI_Q30;
    x      = back_h ? PI_Q30 - a : a;
    x2     = (x * x) >> 30;
    ts     = x;
    tc     = ONE_Q30;
    ss     = $signed(x);
    sc     = $signed(ONE_Q30);
    for (int n = 1; n <= 7; n++) begin
      ts = ((ts * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      tc = ((tc * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
      if ((n & 1) != 0) begin
        ss = ss - $signed(ts);
        sc = sc - $signed(tc);
      end else begin
        ss = ss + $signed(ts);
        sc = sc + $signed(tc);
      end
    end
    s14 = q30_to_q14(ss);
    c14 = q30_to_q14(sc);
    cv  = back_h ? 16'd0 - c14 : c14;
    return {s14, cv};
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic             half,
                                                  input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col);
    return (ADDR_W'(half) * ADDR_W'(ROWS) + ADDR_W'(row)) * ADDR_W'(RHO_BINS) +
           ADDR_W'(col);
  endfunction

  logic signed [15:0] sin_tab [THETA_BINS];
  logic signed [15:0] cos_tab [THETA_BINS];

  for (genvar gi = 0; gi < THETA_BINS; gi++) begin : g_rom
    localparam logic [31:0] ENTRY = rom_entry(gi);
    assign sin_tab[gi] = ENTRY[31:16];
    assign cos_tab[gi] = ENTRY[15:0];
  end

  back_state_t state_r, state_nxt;

  // Item held while it executes.
  mode_t      mode_r;
  logic [7:0] row_r, col_r;
  logic       hit_r;

  // Angle walk pipeline.
  logic [TC_W-1:0]    t_r;
  logic               v1_r, v2_r, v3_r, v4_r, v5_r;
  logic signed [24:0] p1_a_r, p1_b_r;
  logic [T_W-1:0]     p1_t_r, p2_t_r, p3_t_r;
  logic [24:0]        p2_mag_r;
  logic               p2_neg_r, p3_neg_r;
  logic [QW-1:0]      p3_q_r;
  logic [ADDR_W-1:0]  addr4_r, addr5_r;

  // Suppression sweep.
  logic                  half_r;
  logic [ROW_W-1:0]      srow_r;
  logic [COL_W-1:0]      scol_r;
  sup_step_t             step_r;
  logic [COUNT_BITS-1:0] sv_r, sl_r, sr_r, su_r;

  // Clearing sweep.
  logic [ADDR_W-1:0] clr_r;

  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
  logic [COUNT_BITS-1:0] ram_wdata, ram_rdata;

  logic                  issue, walk_done, clr_last, col_last, sup_done, sup_zero;
  logic [ADDR_W-1:0]     center, sup_raddr;
  logic signed [25:0]    sum26;
  logic [37:0]           prod38;
  logic [SW-1:0]         q_ext, top_ext, q_sat;

  // ---------------- angle walk datapath ----------------
  assign issue     = (state_r == ST_WALK) && (t_r < TC_W'(THETA_BINS));
  assign walk_done = (t_r == TC_W'(THETA_BINS)) &&
                     !(v1_r || v2_r || v3_r || v4_r || v5_r);

  assign sum26   = 26'(p1_a_r) + 26'(p1_b_r);
  assign prod38  = 38'(p2_mag_r) * 38'(cfg.rho_recip);
  assign q_ext   = SW'(p3_q_r);
  assign top_ext = SW'(rho_bins_used - RBU_W'(3));
  assign q_sat   = (q_ext > top_ext) ? top_ext : q_ext;

  always_ff @(posedge clk) begin
    p1_a_r   <= $signed({1'b0, row_r}) * sin_tab[t_r[T_W-1:0]];
    p1_b_r   <= $signed({1'b0, col_r}) * cos_tab[t_r[T_W-1:0]];
    p1_t_r   <= t_r[T_W-1:0];
    p2_neg_r <= sum26[25];
    p2_mag_r <= 25'(sum26[25] ? -sum26 : sum26);
    p2_t_r   <= p1_t_r;
    p3_q_r   <= prod38[37:26];
    p3_neg_r <= p2_neg_r;
    p3_t_r   <= p2_t_r;
    // A zero magnitude always lands in the positive half.
    addr4_r  <= cell_addr(p3_neg_r && (q_sat != '0), ROW_W'(p3_t_r) + ROW_W'(1),
                          COL_W'(q_sat) + COL_W'(1));
    addr5_r  <= addr4_r;
  end

  // ---------------- suppression addressing ----------------
  assign center   = cell_addr(half_r, srow_r, scol_r);
  assign col_last = ((RBU_W+1)'(scol_r) + (RBU_W+1)'(2)) >= (RBU_W+1)'(rho_bins_used);
  assign sup_done = (step_r == SS_DECIDE) && col_last &&
                    (srow_r == ROW_W'(THETA_BINS)) && half_r;
  assign sup_zero = (CMP_W'(sv_r) < CMP_W'(cfg.threshold)) || (sv_r < sl_r) ||
                    (sv_r < sr_r) || (sv_r < su_r) || (sv_r < ram_rdata);

  always_comb begin
    case (step_r)
      SS_LEFT:  sup_raddr = center - ADDR_W'(1);
      SS_RIGHT: sup_raddr = center + ADDR_W'(1);
      SS_UP:    sup_raddr = center - ADDR_W'(RHO_BINS);
      SS_DOWN:  sup_raddr = center + ADDR_W'(RHO_BINS);
      default:  sup_raddr = center;
    endcase
  end

  assign clr_last = (clr_r == ADDR_W'(DEPTH - 1));

  // ---------------- store ports ----------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr5_r;
    ram_wdata = '0;
    ram_raddr = addr4_r;
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
      end
      ST_WALK: begin
        ram_we    = v5_r && (mode_r == MODE_VOTE);
        ram_wdata = (ram_rdata == COUNT_MAX) ? ram_rdata : ram_rdata + COUNT_BITS'(1);
      end
      ST_SUPPRESS: begin
        ram_raddr = sup_raddr;
        ram_waddr = center;
        ram_we    = (step_r == SS_DECIDE) && sup_zero;
      end
      default: ;
    endcase
  end

  hlvs_ram #(
    .W     (COUNT_BITS),
    .DEPTH (DEPTH)
  ) u_acc (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // ---------------- sequencer ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    item_pop    = 1'b0;
    res_valid   = 1'b0;
    res_on_line = hit_r;
    init_busy   = (state_r == ST_INIT);
    case (state_r)
      ST_INIT, ST_CLEAR: begin
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid) begin
          item_pop = 1'b1;
          case (item.mode)
            MODE_VOTE:     state_nxt = item.active ? ST_WALK : ST_IDLE;
            MODE_SUPPRESS: state_nxt = ST_SUPPRESS;
            MODE_QUERY:    state_nxt = item.active ? ST_WALK : ST_RESULT;
            MODE_CLEAR:    state_nxt = ST_CLEAR;
            default:       state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (walk_done) state_nxt = (mode_r == MODE_QUERY) ? ST_RESULT : ST_IDLE;
      end
      ST_SUPPRESS: begin
        if (sup_done) state_nxt = ST_IDLE;
      end
      ST_RESULT: begin
        if (!res_full) begin
          res_valid = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r  <= '0;
      t_r    <= '0;
      v1_r   <= 1'b0;
      v2_r   <= 1'b0;
      v3_r   <= 1'b0;
      v4_r   <= 1'b0;
      v5_r   <= 1'b0;
      hit_r  <= 1'b0;
      half_r <= 1'b0;
      srow_r <= ROW_W'(1);
      scol_r <= COL_W'(1);
      step_r <= SS_CENTER;
      mode_r <= MODE_VOTE;
    end else begin
      v1_r <= issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      if (issue) t_r <= t_r + TC_W'(1);
      if ((state_r == ST_INIT) || (state_r == ST_CLEAR)) clr_r <= clr_r + ADDR_W'(1);
      if ((state_r == ST_WALK) && v5_r && (ram_rdata != '0)) hit_r <= 1'b1;
      if (item_pop) begin
        mode_r <= item.mode;
        t_r    <= '0;
        hit_r  <= 1'b0;
        clr_r  <= '0;
        half_r <= 1'b0;
        srow_r <= ROW_W'(1);
        scol_r <= COL_W'(1);
        step_r <= SS_CENTER;
      end
      if (state_r == ST_SUPPRESS) begin
        if (step_r == SS_DECIDE) begin
          step_r <= SS_CENTER;
          if (!col_last) begin
            scol_r <= scol_r + COL_W'(1);
          end else begin
            scol_r <= COL_W'(1);
            if (srow_r != ROW_W'(THETA_BINS)) begin
              srow_r <= srow_r + ROW_W'(1);
            end else begin
              srow_r <= ROW_W'(1);
              half_r <= 1'b1;
            end
          end
        end else begin
          step_r <= sup_step_t'(step_r + 3'd1);
        end
      end
    end
  end

  // Neighbor values arrive in the cycle after their read is issued.
  always_ff @(posedge clk) begin
    case (step_r)
      SS_LEFT:  sv_r <= ram_rdata;
      SS_RIGHT: sl_r <= ram_rdata;
      SS_UP:    sr_r <= ram_rdata;
      SS_DOWN:  su_r <= ram_rdata;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    row_r <= item_pop ? item.row : row_r;
    col_r <= item_pop ? item.col : col_r;
  end

endmodule

### sv/hough_line_vote_suppress_mark.sv
// ----------------------------------------------------------------------------
// hough_line_vote_suppress_mark
// Hough line accumulator with in-place neighbor suppression and on-line
// marking of pixels.
// ----------------------------------------------------------------------------
// Pixels enter through a push/full queue, each with a mode. A vote pixel that
// is nonzero and inside the image adds one, saturating, to one rho cell for
// each of the THETA_BINS angles; a query pixel produces exactly one result
// transaction telling whether any of its cells is nonzero; suppress zeroes,
// in place, every cell below the threshold or below a rho or angle neighbor;
// clear empties the store. Only queries produce results. A vote or query
// walks the angles through a five-stage rho pipeline with one store
// read-modify-write per angle. Suppression reads five cells and
// conditionally writes one for every visited cell. Clear writes one store
// word per cycle. The same clearing sweep runs after reset, and in_full
// stays high until it finishes; configuration writes are accepted at any
// time but must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module hough_line_vote_suppress_mark #(
  parameter int THETA_BINS = hlvs_pkg::DEF_THETA_BINS,
  parameter int RHO_BINS   = hlvs_pkg::DEF_RHO_BINS,
  parameter int COUNT_BITS = hlvs_pkg::DEF_COUNT_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input transactions.
  input  logic        in_push,
  output logic        in_full,
  input  logic [1:0]  in_mode,
  input  logic [7:0]  in_pix_row,
  input  logic [7:0]  in_pix_col,
  input  logic [7:0]  in_pix_value,
  // Result transactions.
  output logic        out_empty,
  input  logic        out_pop,
  output logic        out_on_line,
  // Configuration writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  import hlvs_pkg::*;

  localparam int RBU_W = $clog2(RHO_BINS + 1);

  // Number of rho columns in use, including the guard columns. The highest
  // reachable magnitude is rho_bins_used - 3, which is also where large rho
  // values saturate.
  function automatic logic [RBU_W-1:0] rbu_calc(input logic [8:0]  w_in,
                                                input logic [8:0]  h_in,
                                                input logic [12:0] recip);
    logic [8:0]  w, h, mx;
    logic [23:0] diag, big, r;
    logic [36:0] prod;
    logic [11:0] m;
    w    = side_clip(w_in);
    h    = side_clip(h_in);
    mx   = (w > h) ? w : h;
    diag = 24'(10'(w) + 10'(h)) * 24'(SIN_QUARTER_Q14);
    big  = 24'(mx) << 14;
    r    = (diag > big) ? diag : big;
    prod = 37'(r) * 37'(recip);
    m    = 12'(prod[36:26]) + 12'd3;
    return (32'(m) > RHO_BINS) ? RBU_W'(RHO_BINS) : RBU_W'(m);
  endfunction

  logic [16:0]      threshold_r;
  logic [8:0]       width_r, height_r;
  logic [12:0]      recip_r;
  logic [RBU_W-1:0] rbu_r;

  back_cfg_t bcfg;
  item_t     item;
  logic      item_valid, item_pop, init_busy;
  logic      res_valid, res_on_line, out_full_i;

  // The configuration port never stalls.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r <= RST_THRESHOLD;
      width_r     <= RST_WIDTH;
      height_r    <= RST_HEIGHT;
      recip_r     <= RST_RHO_RECIP;
      rbu_r       <= rbu_calc(RST_WIDTH, RST_HEIGHT, RST_RHO_RECIP);
    end else begin
      // The column count follows the registers in the next cycle; the store
      // itself is not touched when a register changes.
      rbu_r <= rbu_calc(width_r, height_r, recip_r);
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_THRESHOLD: threshold_r <= cfg_data;
          CFG_WIDTH:     width_r     <= cfg_data[8:0];
          CFG_HEIGHT:    height_r    <= cfg_data[8:0];
          CFG_RHO_RECIP: recip_r     <= cfg_data[12:0];
          default:       ;
        endcase
      end
    end
  end

  assign bcfg.threshold = threshold_r;
  assign bcfg.rho_recip = recip_r;

  // Front end: accepts and classifies pixels into a short item queue.
  hlvs_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .push         (in_push),
    .full         (in_full),
    .mode         (in_mode),
    .pix_row      (in_pix_row),
    .pix_col      (in_pix_col),
    .pix_value    (in_pix_value),
    .image_width  (width_r),
    .image_height (height_r),
    .hold         (init_busy),
    .item_valid   (item_valid),
    .item         (item),
    .item_pop     (item_pop)
  );

  // Back end: owns the accumulator store and runs one item at a time.
  hlvs_back #(
    .THETA_BINS (THETA_BINS),
    .RHO_BINS   (RHO_BINS),
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .item_valid    (item_valid),
    .item          (item),
    .item_pop      (item_pop),
    .cfg           (bcfg),
    .rho_bins_used (rbu_r),
    .init_busy     (init_busy),
    .res_valid     (res_valid),
    .res_on_line   (res_on_line),
    .res_full      (out_full_i)
  );

  // Result queue: holds finished query answers until they are popped.
  hlvs_fifo #(
    .W     (1),
    .DEPTH (RES_Q_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_valid),
    .din   (res_on_line),
    .full  (out_full_i),
    .pop   (out_pop),
    .dout  (out_on_line),
    .empty (out_empty)
  );

  // While the store is being cleared after reset no pixel may enter.
  a_init_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    init_busy |-> in_full)
    else $error("pixel accepted during the post-reset clearing sweep");

  // A query answer is only produced when the result queue has room.
  a_result_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid |-> !out_full_i)
    else $error("query result pushed into a full result queue");

  // The column count always leaves room for both guard columns.
  a_rbu_range: assert property (@(posedge clk) disable iff (!rst_n)
    (rbu_r >= RBU_W'(3)) && (32'(rbu_r) <= RHO_BINS))
    else $error("rho column count out of range");

endmodule

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hough line vote / suppress / mark testbench
// Drives pixel transactions in all four modes and register writes, keeps its
// own copy of the accumulator and predicts every query answer. The predicted
// answers are checked in order against the result transactions.
// ----------------------------------------------------------------------------
module tb_top;
  import hlvs_pkg::*;

  localparam int NTHETA   = DEF_THETA_BINS;
  localparam int NRHO     = DEF_RHO_BINS;
  localparam int HALF_SZ  = (NTHETA + 2) * NRHO;
  localparam int CNT_TOP  = (1 << DEF_COUNT_BITS) - 1;
  localparam int N_RANDOM = 2000;
  // Cycles a vote or query needs at most, with margin for the pipeline.
  localparam int WALK_COST  = NTHETA + 40;
  localparam int CLEAR_COST = 2 * HALF_SZ + 2000;

  logic        clk;
  logic        rst_n;
  logic        in_push;
  logic        in_full;
  logic [1:0]  in_mode;
  logic [7:0]  in_pix_row;
  logic [7:0]  in_pix_col;
  logic [7:0]  in_pix_value;
  logic        out_empty;
  logic        out_pop;
  logic        out_on_line;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [16:0] cfg_data;

  hough_line_vote_suppress_mark u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_mode     (in_mode),
    .in_pix_row  (in_pix_row),
    .in_pix_col  (in_pix_col),
    .in_pix_value(in_pix_value),
    .out_empty   (out_empty),
    .out_pop     (out_pop),
    .out_on_line (out_on_line),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Clock with a 12 ns period.
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // The predictor's own state: angle tables, registers and the vote store.
  int          sin_q14 [NTHETA];
  int          cos_q14 [NTHETA];
  bit [16:0]   votes [2 * HALF_SZ];
  bit [16:0]   thr_reg;
  bit [8:0]    width_reg;
  bit [8:0]    height_reg;
  bit [12:0]   recip_reg;
  int          bins_used;

  bit          on_line_q[$];
  int          mismatches;
  int          snd_idle;
  int          rcv_idle;
  longint      cyc;
  longint      busy_until;

  always @(posedge clk) cyc <= cyc + 1;

  // Q2.30 to Q1.14 with clamping to [0, 1] and rounding half up.
  function automatic int round_q14(longint v);
    if (v < 0) v = 0;
    if (v > 64'sd1073741824) v = 64'sd1073741824;
    return int'((v + 32768) >>> 16);
  endfunction

  // Builds the angle tables by an eight-term Taylor series in Q2.30,
  // folding angles past a right angle back into the first quadrant.
  task automatic build_angle_tables();
    longint unsigned a, x, x2, ts, tc;
    longint          ss, sc;
    bit              back;
    for (int k = 0; k < NTHETA; k++) begin
      a    = (PI_Q30 * longint'(k)) / NTHETA;
      back = a > HALF_PI_Q30;
      x    = back ? PI_Q30 - a : a;
      x2   = (x * x) >> 30;
      ts   = x;
      tc   = ONE_Q30;
      ss   = longint'(x);
      sc   = longint'(ONE_Q30);
      for (int n = 1; n <= 7; n++) begin
        ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
        tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
        if (n % 2 == 1) begin
          ss -= longint'(ts);
          sc -= longint'(tc);
        end else begin
          ss += longint'(ts);
          sc += longint'(tc);
        end
      end
      sin_q14[k] = round_q14(ss);
      cos_q14[k] = back ? -round_q14(sc) : round_q14(sc);
    end
  endtask

  function automatic int clip_side(bit [8:0] v);
    return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  // Number of rho columns in use, from the image diagonal and bin size.
  function automatic int rho_columns();
    longint unsigned w, h, diag, big, r, m;
    w    = clip_side(width_reg);
    h    = clip_side(height_reg);
    diag = (w + h) * SIN_QUARTER_Q14;
    big  = ((w > h) ? w : h) << 14;
    r    = (diag > big) ? diag : big;
    m    = ((r * recip_reg) >> 26) + 3;
    return (m > NRHO) ? NRHO : int'(m);
  endfunction

  // Store address of the cell that pixel (row, col) hits at angle t.
  function automatic int vote_cell(int t, int row, int col);
    longint          s;
    longint unsigned mag, q;
    int              half;
    s   = longint'(row) * sin_q14[t] + longint'(col) * cos_q14[t];
    mag = (s < 0) ? longint'(-s) : longint'(s);
    q   = (mag * recip_reg) >> 26;
    if (q > bins_used - 3) q = bins_used - 3;
    // Zero rho always lands in the positive half.
    half = (s < 0 && q != 0) ? 1 : 0;
    return half * HALF_SZ + (t + 1) * NRHO + int'(q) + 1;
  endfunction

  // Non-maximum suppression in place; later cells see earlier zeroing.
  task automatic suppress_votes();
    int        i;
    bit [16:0] v;
    for (int half = 0; half < 2; half++)
      for (int t = 0; t < NTHETA; t++)
        for (int c = 1; c + 1 < bins_used; c++) begin
          i = half * HALF_SZ + (t + 1) * NRHO + c;
          v = votes[i];
          if (v < thr_reg || v < votes[i - 1] || v < votes[i + 1] ||
              v < votes[i - NRHO] || v < votes[i + NRHO])
            votes[i] = '0;
        end
  endtask

  // Applies one accepted pixel transaction to the predicted state and queues
  // the expected answer for a query. Also extends the estimate of how long
  // the block stays busy, which is used before register writes.
  task automatic apply_pixel(mode_t m, int row, int col, int val);
    bit hit;
    bit active;
    int i;
    int cost;
    active = val != 0 && row < clip_side(height_reg) && col < clip_side(width_reg);
    hit    = 1'b0;
    cost   = WALK_COST;
    case (m)
      MODE_VOTE: begin
        if (active)
          for (int t = 0; t < NTHETA; t++) begin
            i = vote_cell(t, row, col);
            if (votes[i] < CNT_TOP) votes[i] = votes[i] + 1;
          end
      end
      MODE_SUPPRESS: begin
        suppress_votes();
        cost = 6 * 2 * NTHETA * bins_used + 500;
      end
      MODE_CLEAR: begin
        foreach (votes[k]) votes[k] = '0;
        cost = CLEAR_COST;
      end
      default: begin
        if (active)
          for (int t = 0; t < NTHETA; t++)
            if (votes[vote_cell(t, row, col)] != 0) hit = 1'b1;
        on_line_q.push_back(hit);
      end
    endcase
    busy_until = ((busy_until > cyc) ? busy_until : cyc) + cost;
  endtask

  // Sends one pixel transaction. The push line stays high between
  // back-to-back transactions so it is never lowered and raised in one step.
  task automatic send_pixel(mode_t m, int row, int col, int val);
    while ($urandom_range(99) < snd_idle) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push      <= 1'b1;
    in_mode      <= m;
    in_pix_row   <= 8'(row);
    in_pix_col   <= 8'(col);
    in_pix_value <= 8'(val);
    do @(posedge clk); while (in_full);
    apply_pixel(m, row, col, val);
  endtask

  // Waits until every answer has come back and the block has had time to
  // finish any trailing vote, suppression or clear.
  task automatic wait_idle();
    in_push <= 1'b0;
    @(posedge clk);
    while (on_line_q.size() != 0 || cyc < busy_until + 50) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, int value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 17'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_THRESHOLD: thr_reg    = 17'(value);
      CFG_WIDTH:     width_reg  = 9'(value);
      CFG_HEIGHT:    height_reg = 9'(value);
      default:       recip_reg  = 13'(value);
    endcase
    bins_used = rho_columns();
  endtask

  // Registers are only written while the block is idle.
  task automatic setup_image(int thr, int w, int h, int recip);
    wait_idle();
    write_reg(CFG_THRESHOLD, thr);
    write_reg(CFG_WIDTH, w);
    write_reg(CFG_HEIGHT, h);
    write_reg(CFG_RHO_RECIP, recip);
  endtask

  // Image corners, zero pixels and queries at the default settings, then a
  // tiny image with the coarsest rho bins for outside pixels, suppression
  // and clear.
  task automatic test_directed();
    send_pixel(MODE_VOTE, 0, 0, 255);
    send_pixel(MODE_VOTE, 255, 255, 1);
    send_pixel(MODE_VOTE, 255, 0, 128);
    send_pixel(MODE_VOTE, 0, 255, 127);
    send_pixel(MODE_VOTE, 100, 50, 0);
    send_pixel(MODE_QUERY, 0, 0, 255);
    send_pixel(MODE_QUERY, 255, 255, 1);
    send_pixel(MODE_QUERY, 100, 50, 0);
    send_pixel(MODE_QUERY, 170, 85, 85);
    setup_image(0, 4, 3, 256);
    send_pixel(MODE_VOTE, 200, 1, 9);
    send_pixel(MODE_VOTE, 1, 200, 9);
    send_pixel(MODE_QUERY, 200, 1, 9);
    send_pixel(MODE_VOTE, 2, 3, 5);
    send_pixel(MODE_VOTE, 1, 1, 5);
    send_pixel(MODE_SUPPRESS, 0, 0, 0);
    send_pixel(MODE_QUERY, 2, 3, 5);
    send_pixel(MODE_QUERY, 0, 0, 7);
    send_pixel(MODE_CLEAR, 0, 0, 0);
    send_pixel(MODE_QUERY, 2, 3, 5);
  endtask

  // Mostly votes and queries on pixels inside the image, with zero pixels,
  // outside pixels and, where the rho range is small, an occasional
  // suppression pass.
  task automatic test_random(int count);
    int    roll;
    int    row;
    int    col;
    int    val;
    mode_t m;
    for (int n = 0; n < count; n++) begin
      roll = $urandom_range(999);
      if (roll < 6 && bins_used <= 30) m = MODE_SUPPRESS;
      else if (roll < 640) m = MODE_VOTE;
      else m = MODE_QUERY;
      if ($urandom_range(9) < 8) begin
        row = $urandom_range(clip_side(height_reg) - 1);
        col = $urandom_range(clip_side(width_reg) - 1);
      end else begin
        row = $urandom_range(255);
        col = $urandom_range(255);
      end
      val = ($urandom_range(7) == 0) ? 0 : $urandom_range(255, 1);
      send_pixel(m, row, col, val);
    end
  endtask

  // Checks each result transaction against the oldest predicted answer.
  always @(posedge clk) begin
    if (rst_n && !out_empty && out_pop) begin
      if (on_line_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result transaction: on_line=%0b", out_on_line);
      end else begin
        if (out_on_line !== on_line_q[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("on_line mismatch: expected %0b actual %0b",
                     on_line_q[0], out_on_line);
        end
        void'(on_line_q.pop_front());
      end
    end
    out_pop <= ($urandom_range(99) >= rcv_idle);
  end

  initial begin
    rst_n        = 1'b0;
    in_push      = 1'b0;
    in_mode      = MODE_VOTE;
    in_pix_row   = '0;
    in_pix_col   = '0;
    in_pix_value = '0;
    out_pop      = 1'b0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_THRESHOLD;
    cfg_data     = '0;
    mismatches   = 0;
    snd_idle     = 36;
    rcv_idle     = 59;
    cyc          = 0;
    thr_reg      = RST_THRESHOLD;
    width_reg    = RST_WIDTH;
    height_reg   = RST_HEIGHT;
    recip_reg    = RST_RHO_RECIP;
    build_angle_tables();
    bins_used = rho_columns();
    foreach (votes[k]) votes[k] = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    // The store is swept clear after reset.
    busy_until = cyc + CLEAR_COST;

    test_directed();
    setup_image(3, 16, 16, 4096);
    test_random(N_RANDOM / 3);
    snd_idle = 59;
    rcv_idle = 36;
    setup_image(65536, 1, 256, 256);
    test_random(N_RANDOM / 6);
    setup_image(2, 256, 256, 4096);
    test_random(N_RANDOM / 6);
    snd_idle = 0;
    rcv_idle = 0;
    setup_image(1, 12, 9, 1500);
    test_random(N_RANDOM / 3);
    wait_idle();

    if (mismatches == 0 && on_line_q.size() == 0) begin
      $display("PASS hough_line_vote_suppress_mark");
    end else begin
      $display("FAIL hough_line_vote_suppress_mark");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #(64'd12 * 64'd8_000_000);
    $display("FAIL hough_line_vote_suppress_mark");
    $finish;
  end

endmodule

### sim.f
sv/hlvs_pkg.sv
sv/hlvs_ram.sv
sv/hlvs_fifo.sv
sv/hlvs_front.sv
sv/hlvs_back.sv
sv/hough_line_vote_suppress_mark.sv
verif/tb_top.sv
